// ===== rtl/core/sdt_pkg.sv =====
// Shared types and constants for the service description section parser.
// Holds the input and result transfer structs and the field codes.
// No dependencies.
`timescale 1ns / 1ps

package sdt_pkg;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_TID      = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TEXT = 1'd1;

  localparam logic [7:0] TID_RESET      = 8'h42;
  localparam logic [7:0] MAX_TEXT_RESET = 8'd63;

  localparam logic [7:0]  TAG_SERVICE  = 8'h48;
  localparam logic [7:0]  LEN_MASK     = 8'h0F;
  localparam logic [11:0] HEADER_BYTES = 12'd11;
  localparam logic [7:0]  ENTRY_HEAD   = 8'd5;
  localparam logic [13:0] CRC_BYTES    = 14'd4;

  localparam logic [2:0] KIND_PROV_CHAR  = 3'd0;
  localparam logic [2:0] KIND_NAME_CHAR  = 3'd1;
  localparam logic [2:0] KIND_PROV_EMPTY = 3'd2;
  localparam logic [2:0] KIND_NAME_EMPTY = 3'd3;
  localparam logic [2:0] KIND_STATUS     = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_WRONG = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  typedef struct packed {
    logic [7:0] section_byte;
    logic       first_byte;
    logic       buffer_end;
  } sdt_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] prog_num;
    logic [7:0]  text_char;
    logic        last_char;
    logic [1:0]  status;
  } sdt_out_t;

endpackage

// ===== rtl/core/sdt_service_descriptor_parser.sv =====
// Service description section parser: byte walker, result register and skid stage.
// Depends on sdt_pkg for transfer structs, field codes and constants.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------------
//   in       | to block  | in_valid/in_stall  | sdt_in_t  (one section byte)
//   out      | from block| out_valid/out_stall| sdt_out_t (char, empty or status)
//   cfg      | to block  | cfg_write          | cfg_index, cfg_data
//
// One byte per cycle while in_stall is low: the parse state updates in the cycle a
// byte transfer completes, and its result, if any, lands in the output register at
// the same edge, or, while the output register is stalled, in a skid register that
// holds one result; in_stall rises only while the skid register is full.
// Synchronous reset returns the walker to idle and empties both result registers.
`timescale 1ns / 1ps

module sdt_service_descriptor_parser (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sdt_pkg::sdt_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output sdt_pkg::sdt_out_t                   out_data,
  input  logic                                cfg_write,
  input  logic [sdt_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sdt_pkg::CFG_DATA_W-1:0]      cfg_data
);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_LENHI = 4'd1,
    PH_LENLO = 4'd2,
    PH_HDR   = 4'd3,
    PH_ENTRY = 4'd4,
    PH_DTAG  = 4'd5,
    PH_DLEN  = 4'd6,
    PH_STYPE = 4'd7,
    PH_PLEN  = 4'd8,
    PH_PCHAR = 4'd9,
    PH_NLEN  = 4'd10,
    PH_NCHAR = 4'd11,
    PH_DSKIP = 4'd12,
    PH_ESKIP = 4'd13
  } phase_t;

  logic [7:0] sect_tid;
  logic [7:0] max_text;

  phase_t      phase, phase_next;
  logic [11:0] bpos, bpos_next;
  logic [11:0] slen, slen_next;
  logic [11:0] sle, sle_next;
  logic [11:0] dend, dend_next;
  logic [15:0] svc, svc_next;
  logic [7:0]  srem, srem_next;
  logic        sacc, sacc_next;

  logic              in_accept;
  logic              out_take;
  logic              res_valid;
  sdt_pkg::sdt_out_t res;
  logic              skid_valid;
  sdt_pkg::sdt_out_t skid_data;

  logic [7:0]  b;
  logic [12:0] q;
  logic [13:0] q14;
  logic [13:0] raw_entry;
  logic [13:0] raw_dlen;
  logic [11:0] len_hi;
  logic [7:0]  srem_dec;
  logic        do_entry, do_desc, do_cont, do_end;

  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign in_stall  = skid_valid;

  assign b         = in_data.section_byte;
  assign q         = {1'b0, bpos} + 13'd1;
  assign q14       = {1'b0, q};
  assign raw_entry = q14 + {2'b00, sle | {4'h0, b}};
  assign raw_dlen  = q14 + {6'h00, b};
  assign len_hi    = {(b & sdt_pkg::LEN_MASK) , 4'h0} << 4;
  assign srem_dec  = (srem != 8'd0) ? srem - 8'd1 : 8'd0;

  always_comb begin
    phase_next = phase;
    bpos_next  = bpos;
    slen_next  = slen;
    sle_next   = sle;
    dend_next  = dend;
    svc_next   = svc;
    srem_next  = srem;
    sacc_next  = sacc;
    res_valid  = 1'b0;
    res        = '0;
    do_entry   = 1'b0;
    do_desc    = 1'b0;
    do_cont    = 1'b0;
    do_end     = 1'b0;

    if (in_data.first_byte) begin
      sacc_next = 1'b0;
      if (b != sect_tid) begin
        phase_next = PH_IDLE;
        res_valid  = 1'b1;
        res.kind   = sdt_pkg::KIND_STATUS;
        res.last_char = 1'b1;
        res.status = sdt_pkg::ST_WRONG;
      end else if (in_data.buffer_end) begin
        phase_next = PH_IDLE;
        res_valid  = 1'b1;
        res.kind   = sdt_pkg::KIND_STATUS;
        res.last_char = 1'b1;
        res.status = sdt_pkg::ST_TRUNC;
      end else begin
        phase_next = PH_LENHI;
      end
    end else begin
      case (phase)
        PH_IDLE: begin
          phase_next = PH_IDLE;
        end
        PH_LENHI: begin
          slen_next  = len_hi;
          phase_next = PH_LENLO;
          if (in_data.buffer_end) begin
            phase_next = PH_IDLE;
            res_valid  = 1'b1;
            res.kind   = sdt_pkg::KIND_STATUS;
            res.last_char = 1'b1;
            res.status = sdt_pkg::ST_TRUNC;
          end
        end
        PH_LENLO: begin
          slen_next = slen | {4'h0, b};
          bpos_next = 12'd0;
          if ((slen | {4'h0, b}) == 12'd0) begin
            phase_next = PH_IDLE;
            res_valid  = 1'b1;
            res.kind   = sdt_pkg::KIND_STATUS;
            res.last_char = 1'b1;
            res.status = sdt_pkg::ST_OK;
          end else if (in_data.buffer_end) begin
            phase_next = PH_IDLE;
            res_valid  = 1'b1;
            res.kind   = sdt_pkg::KIND_STATUS;
            res.last_char = 1'b1;
            res.status = sdt_pkg::ST_TRUNC;
          end else begin
            phase_next = PH_HDR;
          end
        end
        PH_HDR: begin
          do_end = 1'b1;
          if (bpos >= sdt_pkg::HEADER_BYTES - 12'd4) do_entry = 1'b1;
        end
        PH_ENTRY: begin
          do_end = 1'b1;
          case (srem)
            8'd0: svc_next = {b, 8'h00};
            8'd1: svc_next = svc | {8'h00, b};
            8'd3: sle_next = len_hi;
            default: svc_next = svc;
          endcase
          if (srem >= sdt_pkg::ENTRY_HEAD - 8'd1) begin
            if (raw_entry + sdt_pkg::CRC_BYTES > {2'b00, slen}) begin
              phase_next = PH_ESKIP;
              sle_next   = 12'hFFF;
            end else begin
              sle_next = raw_entry[11:0];
              do_desc  = 1'b1;
            end
          end else begin
            srem_next = srem + 8'd1;
          end
        end
        PH_DTAG: begin
          do_end     = 1'b1;
          sacc_next  = (b == sdt_pkg::TAG_SERVICE);
          phase_next = PH_DLEN;
        end
        PH_DLEN: begin
          do_end = 1'b1;
          if (raw_dlen <= {2'b00, sle}) begin
            dend_next = raw_dlen[11:0];
            if (sacc && b >= 8'd2) phase_next = PH_STYPE;
            else do_cont = 1'b1;
          end else begin
            dend_next = sle;
            do_cont   = 1'b1;
          end
        end
        PH_STYPE: begin
          do_end     = 1'b1;
          phase_next = PH_PLEN;
        end
        PH_PLEN, PH_NLEN: begin
          do_end = 1'b1;
          if (b <= max_text && raw_dlen <= {2'b00, dend}) begin
            if (b == 8'd0) begin
              res_valid     = 1'b1;
              res.kind      = (phase == PH_PLEN) ? sdt_pkg::KIND_PROV_EMPTY
                                                 : sdt_pkg::KIND_NAME_EMPTY;
              res.prog_num  = svc;
              res.last_char = 1'b1;
              if (phase == PH_PLEN && {1'b0, dend} > q) phase_next = PH_NLEN;
              else do_cont = 1'b1;
            end else begin
              srem_next  = b;
              phase_next = (phase == PH_PLEN) ? PH_PCHAR : PH_NCHAR;
            end
          end else begin
            do_cont = 1'b1;
          end
        end
        PH_PCHAR, PH_NCHAR: begin
          do_end         = 1'b1;
          srem_next      = srem_dec;
          res_valid      = 1'b1;
          res.kind       = (phase == PH_PCHAR) ? sdt_pkg::KIND_PROV_CHAR
                                               : sdt_pkg::KIND_NAME_CHAR;
          res.prog_num   = svc;
          res.text_char  = b;
          res.last_char  = (srem_dec == 8'd0);
          if (srem_dec == 8'd0) begin
            if (phase == PH_PCHAR && {1'b0, dend} > q) phase_next = PH_NLEN;
            else do_cont = 1'b1;
          end
        end
        PH_DSKIP: begin
          do_end  = 1'b1;
          do_cont = 1'b1;
        end
        PH_ESKIP: begin
          do_end = 1'b1;
          if (q >= {1'b0, sle}) do_entry = 1'b1;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase

      if (do_cont) begin
        sacc_next = 1'b0;
        if (q < {1'b0, dend_next}) phase_next = PH_DSKIP;
        else do_desc = 1'b1;
      end
      if (do_desc) begin
        if (q14 + 14'd2 <= {2'b00, sle_next}) phase_next = PH_DTAG;
        else if (q < {1'b0, sle_next}) phase_next = PH_ESKIP;
        else do_entry = 1'b1;
      end
      if (do_entry) begin
        if (q14 + {6'h00, sdt_pkg::ENTRY_HEAD} + sdt_pkg::CRC_BYTES <= {2'b00, slen}) begin
          phase_next = PH_ENTRY;
          srem_next  = 8'd0;
        end else begin
          phase_next = PH_ESKIP;
          sle_next   = 12'hFFF;
        end
      end
      if (do_end) begin
        if (q >= {1'b0, slen}) begin
          phase_next    = PH_IDLE;
          sacc_next     = 1'b0;
          res_valid     = 1'b1;
          res           = '0;
          res.kind      = sdt_pkg::KIND_STATUS;
          res.last_char = 1'b1;
          res.status    = sdt_pkg::ST_OK;
        end else if (in_data.buffer_end) begin
          phase_next    = PH_IDLE;
          sacc_next     = 1'b0;
          res_valid     = 1'b1;
          res           = '0;
          res.kind      = sdt_pkg::KIND_STATUS;
          res.last_char = 1'b1;
          res.status    = sdt_pkg::ST_TRUNC;
        end else begin
          bpos_next = q[11:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sect_tid <= sdt_pkg::TID_RESET;
      max_text <= sdt_pkg::MAX_TEXT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == sdt_pkg::CFG_TID) sect_tid <= cfg_data;
      if (cfg_index == sdt_pkg::CFG_MAX_TEXT) max_text <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      bpos  <= 12'd0;
      slen  <= 12'd0;
      sle   <= 12'd0;
      dend  <= 12'd0;
      svc   <= 16'd0;
      srem  <= 8'd0;
      sacc  <= 1'b0;
    end else if (in_accept) begin
      phase <= phase_next;
      bpos  <= bpos_next;
      slen  <= slen_next;
      sle   <= sle_next;
      dend  <= dend_next;
      svc   <= svc_next;
      srem  <= srem_next;
      sacc  <= sacc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || out_take) begin
      out_valid <= in_accept && res_valid;
    end else if (in_accept && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) out_data <= skid_data;
    end else if (!out_valid || out_take) begin
      if (in_accept && res_valid) out_data <= res;
    end else if (in_accept && res_valid) begin
      skid_data <= res;
    end
  end

  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  assert property (@(posedge clk) disable iff (rst)
    (in_accept && res_valid && res.kind == sdt_pkg::KIND_STATUS) |=> phase == PH_IDLE)
    else $error("walker not idle after section status");

  assert property (@(posedge clk) disable iff (rst)
    (in_accept && res_valid && res.kind == sdt_pkg::KIND_PROV_CHAR) |-> phase == PH_PCHAR)
    else $error("provider character outside provider string");

  assert property (@(posedge clk) disable iff (rst)
    (in_accept && res_valid && res.kind != sdt_pkg::KIND_STATUS) |-> res.status == sdt_pkg::ST_OK)
    else $error("status set on a string result");

endmodule

// ===== sim/tb.sv =====
// Testbench for sdt_service_descriptor_parser: random and directed SDT sections in,
// service strings and section status out, checked against a cycle-free predictor.
// Depends on sdt_pkg and the parser RTL.
`timescale 1ns / 1ps

typedef enum logic [3:0] {
  S_IDLE, S_LEN_HI, S_LEN_LO, S_HEADER, S_ENTRY_HEAD, S_DESC_TAG, S_DESC_LEN,
  S_SVC_TYPE, S_PROV_LEN, S_PROV_TEXT, S_NAME_LEN, S_NAME_TEXT, S_SKIP_DESC, S_SKIP_LOOP
} walk_state_t;

class sdt_section_checker;
  logic [7:0] sect_tid;
  logic [7:0] max_text;

  walk_state_t walk;
  logic [11:0] pos;
  logic [11:0] sec_len;
  logic [11:0] loop_end;
  logic [11:0] desc_end;
  logic [15:0] svc_id;
  logic [7:0]  left;
  logic        in_svc_desc;

  sdt_pkg::sdt_out_t due[$];
  int errors, n_text, n_ok, n_wrong, n_trunc;

  function new();
    sect_tid = sdt_pkg::TID_RESET;
    max_text = sdt_pkg::MAX_TEXT_RESET;
    walk = S_IDLE;
    pos = '0;
    sec_len = '0;
    loop_end = '0;
    desc_end = '0;
    svc_id = '0;
    left = '0;
    in_svc_desc = 1'b0;
  endfunction

  function void set_reg(logic [sdt_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] val);
    if (idx == sdt_pkg::CFG_TID) sect_tid = val;
    else if (idx == sdt_pkg::CFG_MAX_TEXT) max_text = val;
  endfunction

  function int outstanding();
    return due.size();
  endfunction

  function void push_result(logic [2:0] kind, logic [15:0] sid, logic [7:0] ch, logic last,
                            logic [1:0] st);
    sdt_pkg::sdt_out_t r;
    r.kind = kind;
    r.prog_num = sid;
    r.text_char = ch;
    r.last_char = last;
    r.status = st;
    due.push_back(r);
    if (kind != sdt_pkg::KIND_STATUS) n_text++;
    else if (st == sdt_pkg::ST_OK) n_ok++;
    else if (st == sdt_pkg::ST_WRONG) n_wrong++;
    else n_trunc++;
  endfunction

  function void end_section(logic [1:0] st);
    walk = S_IDLE;
    in_svc_desc = 1'b0;
    push_result(sdt_pkg::KIND_STATUS, 16'h0000, 8'h00, 1'b1, st);
  endfunction

  function void open_entry(int q);
    if (q + sdt_pkg::ENTRY_HEAD + sdt_pkg::CRC_BYTES <= sec_len) begin
      walk = S_ENTRY_HEAD;
      left = '0;
    end else begin
      walk = S_SKIP_LOOP;
      loop_end = 12'hFFF;
    end
  endfunction

  function void next_descriptor(int q);
    if (q + 2 <= loop_end) walk = S_DESC_TAG;
    else if (q < loop_end) walk = S_SKIP_LOOP;
    else open_entry(q);
  endfunction

  function void end_descriptor(int q);
    in_svc_desc = 1'b0;
    if (q < desc_end) walk = S_SKIP_DESC;
    else next_descriptor(q);
  endfunction

  function void take_byte(sdt_pkg::sdt_in_t x);
    logic [7:0] b;
    logic [15:0] sid;
    int q, raw;
    bit hit;
    logic [2:0] hit_kind;
    logic [7:0] hit_char;
    logic hit_last;
    b = x.section_byte;
    hit = 1'b0;
    hit_kind = sdt_pkg::KIND_STATUS;
    hit_char = 8'h00;
    hit_last = 1'b1;
    if (x.first_byte) begin
      in_svc_desc = 1'b0;
      if (b != sect_tid) begin
        end_section(sdt_pkg::ST_WRONG);
        return;
      end
      walk = S_LEN_HI;
      if (x.buffer_end) end_section(sdt_pkg::ST_TRUNC);
      return;
    end
    case (walk)
      S_IDLE: return;
      S_LEN_HI: begin
        sec_len = {b[3:0], 8'h00};
        walk = S_LEN_LO;
        if (x.buffer_end) end_section(sdt_pkg::ST_TRUNC);
        return;
      end
      S_LEN_LO: begin
        sec_len = sec_len | {4'h0, b};
        pos = '0;
        if (sec_len == 0) begin
          end_section(sdt_pkg::ST_OK);
          return;
        end
        walk = S_HEADER;
        if (x.buffer_end) end_section(sdt_pkg::ST_TRUNC);
        return;
      end
      default: ;
    endcase

    q = pos + 1;
    sid = svc_id;
    case (walk)
      S_HEADER: begin
        if (pos >= sdt_pkg::HEADER_BYTES - 12'd4) open_entry(q);
      end
      S_ENTRY_HEAD: begin
        if (left == 0) svc_id = {b, 8'h00};
        else if (left == 1) svc_id = svc_id | {8'h00, b};
        else if (left == 3) loop_end = {b[3:0], 8'h00};
        if (left >= sdt_pkg::ENTRY_HEAD - 8'd1) begin
          raw = q + int'(loop_end | {4'h0, b});
          if (raw + sdt_pkg::CRC_BYTES > sec_len) begin
            walk = S_SKIP_LOOP;
            loop_end = 12'hFFF;
          end else begin
            loop_end = 12'(raw);
            next_descriptor(q);
          end
        end else begin
          left++;
        end
      end
      S_DESC_TAG: begin
        in_svc_desc = (b == sdt_pkg::TAG_SERVICE);
        walk = S_DESC_LEN;
      end
      S_DESC_LEN: begin
        raw = q + b;
        if (raw <= loop_end) begin
          desc_end = 12'(raw);
          if (in_svc_desc && b >= 2) walk = S_SVC_TYPE;
          else end_descriptor(q);
        end else begin
          desc_end = loop_end;
          end_descriptor(q);
        end
      end
      S_SVC_TYPE: walk = S_PROV_LEN;
      S_PROV_LEN, S_NAME_LEN: begin
        if (b <= max_text && q + b <= desc_end) begin
          if (b == 0) begin
            hit = 1'b1;
            hit_kind = (walk == S_PROV_LEN) ? sdt_pkg::KIND_PROV_EMPTY
                                            : sdt_pkg::KIND_NAME_EMPTY;
            if (walk == S_PROV_LEN && q < desc_end) walk = S_NAME_LEN;
            else end_descriptor(q);
          end else begin
            left = b;
            walk = (walk == S_PROV_LEN) ? S_PROV_TEXT : S_NAME_TEXT;
          end
        end else begin
          end_descriptor(q);
        end
      end
      S_PROV_TEXT, S_NAME_TEXT: begin
        if (left > 0) left--;
        hit = 1'b1;
        hit_kind = (walk == S_PROV_TEXT) ? sdt_pkg::KIND_PROV_CHAR : sdt_pkg::KIND_NAME_CHAR;
        hit_char = b;
        hit_last = (left == 0);
        if (left == 0) begin
          if (walk == S_PROV_TEXT && q < desc_end) walk = S_NAME_LEN;
          else end_descriptor(q);
        end
      end
      S_SKIP_DESC: end_descriptor(q);
      S_SKIP_LOOP: begin
        if (q >= loop_end) open_entry(q);
      end
      default: begin
        walk = S_IDLE;
        return;
      end
    endcase

    if (q >= sec_len) begin
      end_section(sdt_pkg::ST_OK);
      return;
    end
    if (x.buffer_end) begin
      end_section(sdt_pkg::ST_TRUNC);
      return;
    end
    pos = 12'(q);
    if (hit) push_result(hit_kind, sid, hit_char, hit_last, sdt_pkg::ST_OK);
  endfunction

  function void check_result(sdt_pkg::sdt_out_t got);
    sdt_pkg::sdt_out_t want;
    if (due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("[%0t] result with none pending: kind=%0d sid=%h char=%h last=%b status=%0d",
                 $time, got.kind, got.prog_num, got.text_char, got.last_char, got.status);
      return;
    end
    want = due.pop_front();
    if (got.kind !== want.kind || got.prog_num !== want.prog_num ||
        got.text_char !== want.text_char || got.last_char !== want.last_char ||
        got.status !== want.status) begin
      errors++;
      if (errors <= 10) begin
        $display("[%0t] mismatch: want kind=%0d sid=%h char=%h last=%b status=%0d",
                 $time, want.kind, want.prog_num, want.text_char, want.last_char,
                 want.status);
        $display("          got  kind=%0d sid=%h char=%h last=%b status=%0d",
                 got.kind, got.prog_num, got.text_char, got.last_char, got.status);
      end
    end
  endfunction
endclass

module tb;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_GAP   = 4;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  sdt_pkg::sdt_in_t                in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  sdt_pkg::sdt_out_t               out_data;
  logic                            cfg_write = 1'b0;
  logic [sdt_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [sdt_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  sdt_section_checker chk;
  logic [7:0] sect[$];
  logic [7:0] cur_tid = sdt_pkg::TID_RESET;
  logic [7:0] cur_max_text = sdt_pkg::MAX_TEXT_RESET;
  int  byte_count = 0;
  int  section_count = 0;
  int  burst_left = 1;
  int  gap_left = 0;
  bit  sender_steady = 1'b0;
  bit  rx_calm = 1'b0;
  bit  rx_hold = 1'b0;
  int  rx_left = 0;
  int  quiet = 0;

  sdt_service_descriptor_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // check each output transfer, then pick the next stall run
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) chk.check_result(out_data);
    if (rx_left > 0) begin
      rx_left--;
    end else begin
      rx_left = $urandom_range(1, 16);
      rx_hold = !rx_calm && ($urandom_range(0, 2) == 0);
    end
    out_stall <= rx_hold;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("FAIL sdt_service_descriptor_parser");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic first, input logic bend);
    sdt_pkg::sdt_in_t x;
    x.section_byte = b;
    x.first_byte = first;
    x.buffer_end = bend;
    if (gap_left > 0) begin
      in_valid <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (in_stall);
    chk.take_byte(x);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      if (!sender_steady)
        gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (chk.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sdt_pkg::CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    chk.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic add_text();
    int n, claim;
    case ($urandom_range(0, 9))
      0: n = 0;
      1: n = (cur_max_text < 16) ? cur_max_text + 1 : $urandom_range(0, 12);
      default: n = $urandom_range(1, 8);
    endcase
    claim = n;
    if ($urandom_range(0, 11) == 0) claim = n + $urandom_range(1, 30);
    sect.push_back(8'(claim));
    repeat (n) sect.push_back(8'($urandom));
  endtask

  task automatic add_descriptor();
    int at, n, pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      sect.push_back(sdt_pkg::TAG_SERVICE);
      at = sect.size();
      sect.push_back(8'h00);
      sect.push_back(8'($urandom));
      add_text();
      if ($urandom_range(0, 7) != 0) add_text();
      n = sect.size() - at - 1;
      if ($urandom_range(0, 11) == 0) n = $urandom_range(0, 20);
      sect[at] = 8'(n);
    end else begin
      // service tag too short to hold strings, or some other descriptor
      sect.push_back((pick == 6) ? sdt_pkg::TAG_SERVICE : 8'($urandom));
      n = (pick == 6) ? $urandom_range(0, 1) : $urandom_range(0, 6);
      sect.push_back(8'(n));
      repeat (n) sect.push_back(8'($urandom));
    end
  endtask

  task automatic build_section();
    int at, len;
    sect = {};
    sect.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom) : cur_tid);
    sect.push_back(8'h00);
    sect.push_back(8'h00);
    repeat (8) sect.push_back(8'($urandom));
    repeat ($urandom_range(0, 3)) begin
      sect.push_back(8'($urandom));
      sect.push_back(8'($urandom));
      sect.push_back(8'($urandom));
      at = sect.size();
      sect.push_back(8'h00);
      sect.push_back(8'h00);
      repeat ($urandom_range(0, 3)) add_descriptor();
      len = sect.size() - at - 2;
      if ($urandom_range(0, 11) == 0) len = $urandom_range(0, 60);
      sect[at] = {4'($urandom), 4'(len >> 8)};
      sect[at + 1] = 8'(len);
    end
    repeat (4) sect.push_back(8'($urandom));
    len = sect.size() - 3;
    case ($urandom_range(0, 39))
      0: len = 0;
      1: len = $urandom_range(0, 4095);
      2, 3, 4: len = $urandom_range(0, 80);
      default: ;
    endcase
    sect[1] = {4'($urandom), 4'(len >> 8)};
    sect[2] = 8'(len);
  endtask

  // clean: whole section, buffer end on the last byte
  task automatic send_section(input bit clean);
    int cut, mode, i;
    mode = clean ? 2 : $urandom_range(0, 11);
    cut = sect.size() - 1;
    if (mode < 2) cut = $urandom_range(0, sect.size() - 1);
    for (i = 0; i <= cut; i++)
      send_item(sect[i], i == 0,
                (i == cut) && (mode == 0 || clean || (mode > 1 && $urandom_range(0, 1) == 1)));
    byte_count += cut + 1;
    section_count++;
    if (!clean && $urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3))
        send_item(8'($urandom), $urandom_range(0, 5) == 0, $urandom_range(0, 3) == 0);
  endtask

  task automatic run_phase(input logic [7:0] tid, input logic [7:0] maxlen, input bit calm,
                           input int count);
    int start;
    bit paused;
    wait_drained();
    write_reg(sdt_pkg::CFG_TID, tid);
    write_reg(sdt_pkg::CFG_MAX_TEXT, maxlen);
    cur_tid = tid;
    cur_max_text = maxlen;
    sender_steady = calm;
    rx_calm = calm;
    start = byte_count;
    paused = 1'b0;
    while (byte_count - start < count) begin
      build_section();
      send_section(1'b0);
      if (!paused && byte_count - start > count / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    chk = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // wrong table id, then a stray byte
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    // buffer ends on each of the first three bytes
    send_item(sdt_pkg::TID_RESET, 1'b1, 1'b1);
    send_item(sdt_pkg::TID_RESET, 1'b1, 1'b0);
    send_item(8'hF0, 1'b0, 1'b1);
    send_item(sdt_pkg::TID_RESET, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h05, 1'b0, 1'b1);
    // zero section length
    send_item(sdt_pkg::TID_RESET, 1'b1, 1'b0);
    send_item(8'hF0, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    // one entry, service descriptor with empty provider and name
    sect = {sdt_pkg::TID_RESET, 8'hF0, 8'h16, 8'h12, 8'h34, 8'hC1, 8'h00, 8'h00, 8'h00,
            8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFC, 8'hF0, 8'h05, sdt_pkg::TAG_SERVICE, 8'h03,
            8'h01, 8'h00, 8'h00, 8'hDE, 8'hAD, 8'hBE, 8'hEF};
    send_section(1'b1);

    run_phase(8'h42, 8'd255, 1'b0, 170);
    run_phase(8'hFF, 8'd0, 1'b0, 170);
    run_phase(8'h00, 8'd3, 1'b1, 170);
    run_phase(8'h46, 8'd63, 1'b0, 170);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Covered %0d sections (%0d bytes) over five register settings:",
             section_count, byte_count);
    $display("  %0d string results, status ok/wrong id/truncated %0d/%0d/%0d, %0d errors",
             chk.n_text, chk.n_ok, chk.n_wrong, chk.n_trunc, chk.errors);
    if (chk.errors == 0 && chk.outstanding() == 0) begin
      $display("PASS sdt_service_descriptor_parser");
    end else begin
      $display("FAIL sdt_service_descriptor_parser");
    end
    $finish;
  end
endmodule
